// ===== rtl/skf_pkg.sv =====
// shared constants and types for the scalar kalman filter
package skf_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned MeasW  = 16;
    localparam int unsigned GainW  = 17;
    localparam int unsigned FracW  = 16;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [GainW-1:0] GAIN_ONE = 17'h10000;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_PROCESS_NOISE    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_MEASURE_NOISE    = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_INITIAL_ESTIMATE = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_INITIAL_VARIANCE = 2'd3;

    // register values after reset
    localparam logic [DataW-1:0] RST_PROCESS_NOISE    = 32'd655;
    localparam logic [DataW-1:0] RST_MEASURE_NOISE    = 32'd65536;
    localparam logic [DataW-1:0] RST_INITIAL_ESTIMATE = 32'd0;
    localparam logic [DataW-1:0] RST_INITIAL_VARIANCE = 32'd65536;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_PRED = 6'b000010,
        S_DIV  = 6'b000100,
        S_MULE = 6'b001000,
        S_MULP = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

endpackage

// ===== rtl/scalar_kalman_filter.sv =====
// scalar kalman filter: one sample per transaction; no new sample is taken until the last result is offered
// a sample is accepted only in idle; the result is offered after the predict, divide, multiply and final states
// the gain comes from a 17-step restoring divider
// one shared 34x18 multiplier forms the estimate correction and the new variance
// synchronous active-low reset restores control and configuration and reloads the state
module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [MeasW-1:0]   i_measurement,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DataW-1:0]   o_estimate,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [DataW-1:0]          i_cfg_data
);

    t_state r_state, n_state;

    logic [DataW-1:0]         r_q, r_r;
    logic signed [DataW-1:0]  r_est;
    logic [DataW-1:0]         r_var;
    logic signed [MeasW-1:0]  r_meas;
    logic [DataW-1:0]         r_p;
    logic [DataW:0]           r_den;
    logic signed [DataW:0]    r_resid;
    logic [DataW+1:0]         r_rem;
    logic [GainW-1:0]         r_quo;
    logic [4:0]               r_cnt;
    logic signed [51:0]       r_prod;
    logic                     r_out_valid;
    logic signed [DataW-1:0]  r_out_est;

    logic                     w_in_acc, w_cfg_acc, w_out_free;
    logic [DataW:0]           w_psum;
    logic [DataW-1:0]         w_p;
    logic [DataW+2:0]         w_diff;
    logic                     w_ge;
    logic [DataW+1:0]         w_rem_next;
    logic signed [33:0]       w_mul_a;
    logic signed [17:0]       w_mul_b;
    logic signed [51:0]       w_prod;
    logic signed [51:0]       w_round;
    logic signed [36:0]       w_nx;
    logic [48:0]              w_pv;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_estimate  = r_out_est;

    // predicted variance, saturating
    assign w_psum = {1'b0, r_var} + {1'b0, r_q};
    assign w_p    = w_psum[DataW] ? {DataW{1'b1}} : w_psum[DataW-1:0];

    // one restoring division step
    assign w_diff     = {1'b0, r_rem} - {2'b00, r_den};
    assign w_ge       = !w_diff[DataW+2];
    assign w_rem_next = w_ge ? w_diff[DataW+1:0] : r_rem;

    // shared multiplier operands
    always_comb begin
        if (r_state == S_MULE) begin
            w_mul_a = {r_resid[DataW], r_resid};
            w_mul_b = {1'b0, r_quo};
        end else begin
            w_mul_a = {2'b00, r_p};
            w_mul_b = {1'b0, GAIN_ONE - r_quo};
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    // rounded correction added to the estimate, ties upward
    assign w_round = r_prod + 52'sd32768;
    assign w_nx    = {{5{r_est[DataW-1]}}, r_est} + {w_round[51], w_round[51:16]};
    assign w_pv    = r_prod[48:0] + 49'd32768;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_PRED;
            S_PRED: n_state = S_DIV;
            S_DIV:  if (r_cnt == 5'd0) n_state = S_MULE;
            S_MULE: n_state = S_MULP;
            S_MULP: n_state = S_FIN;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q         <= RST_PROCESS_NOISE;
            r_r         <= RST_MEASURE_NOISE;
            r_est       <= RST_INITIAL_ESTIMATE;
            r_var       <= RST_INITIAL_VARIANCE;
            r_out_valid <= 1'b0;
            r_cnt       <= 5'd0;
        end else begin
            r_state <= n_state;
            // the final step raises valid itself
            if (r_out_valid && !i_out_stall && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg_acc) begin
                        case (i_cfg_index)
                            REG_PROCESS_NOISE:    r_q <= i_cfg_data;
                            REG_MEASURE_NOISE:    r_r <= i_cfg_data;
                            REG_INITIAL_ESTIMATE: r_est <= i_cfg_data;
                            REG_INITIAL_VARIANCE: r_var <= i_cfg_data;
                            default: ;
                        endcase
                    end
                end
                S_PRED: begin
                    r_cnt <= 5'd16;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 5'd1;
                end
                S_MULP: begin
                    if (w_nx > 37'sd2147483647) begin
                        r_est <= 32'h7FFF_FFFF;
                    end else if (w_nx < -37'sd2147483648) begin
                        r_est <= 32'h8000_0000;
                    end else begin
                        r_est <= w_nx[DataW-1:0];
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_var       <= w_pv[47:16];
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_meas <= i_measurement;
        end
        case (r_state)
            S_PRED: begin
                r_p     <= w_p;
                r_den   <= {1'b0, w_p} + {1'b0, r_r};
                r_rem   <= {2'b00, w_p};
                r_quo   <= '0;
                r_resid <= {r_meas[MeasW-1], r_meas, 16'h0000}
                           - {r_est[DataW-1], r_est};
            end
            S_DIV: begin
                r_rem <= {w_rem_next[DataW:0], 1'b0};
                if (r_cnt == 5'd0 && r_den == '0) begin
                    r_quo <= GAIN_ONE;
                end else begin
                    r_quo <= {r_quo[GainW-2:0], w_ge};
                end
            end
            S_MULE, S_MULP: begin
                r_prod <= w_prod;
            end
            S_FIN: begin
                if (w_out_free) begin
                    r_out_est <= r_est;
                end
            end
            default: ;
        endcase
    end

    // gain never exceeds one once the division is done
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULE) |-> (r_quo <= GAIN_ONE))
        else $error("gain above one after division");

    // a new result appears only at the end of the final step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside final step");

    // division always runs its full count before the multiplies
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULE) |-> ($past(r_state == S_DIV) && $past(r_cnt == 5'd0)))
        else $error("multiply entered before division finished");

endmodule
